// ----- rtl/tpq_pkg.sv -----
package tpq_pkg;

    // Width of the stored payload identifier.
    localparam int unsigned TAG_BITS = 16;

    // Number of priority levels.
    localparam int unsigned NUM_LEVELS = 3;

    // Command codes.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_ACCEL = 2'd2;

    // Level codes.
    localparam logic [1:0] LVL_LOW    = 2'd0;
    localparam logic [1:0] LVL_NORMAL = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]          command;
        logic [1:0]          priority_req;
        logic [TAG_BITS-1:0] tag;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [TAG_BITS-1:0] out_tag;
        logic [1:0]          out_level;
    } rsp_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_FULL,
        OP_GET,
        OP_EMPTY,
        OP_ACCEL
    } op_t;

    // Enables from the list controller to the entry store.
    typedef struct packed {
        logic rd_en;
        logic tag_we;
        logic next_we;
    } mem_ctl_t;

endpackage

// ----- rtl/tpq_store.sv -----
module tpq_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6
) (
    input  logic                         clk,
    input  tpq_pkg::mem_ctl_t            ctl,
    input  logic [IDX_W-1:0]             rd_addr,
    input  logic [IDX_W-1:0]             tag_waddr,
    input  logic [tpq_pkg::TAG_BITS-1:0] tag_wdata,
    input  logic [IDX_W-1:0]             next_waddr,
    input  logic [IDX_W-1:0]             next_wdata,
    output logic [tpq_pkg::TAG_BITS-1:0] rd_tag,
    output logic [IDX_W-1:0]             rd_next
);

    // Payload and link memories, one read and one write port each.
    logic [tpq_pkg::TAG_BITS-1:0] tag_mem [0:DEPTH-1];
    logic [IDX_W-1:0]             next_mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (ctl.tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_tag <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_next <= next_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/tpq_ctrl.sv -----
module tpq_ctrl #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6,
    parameter int unsigned CNT_W = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  tpq_pkg::req_t                request,
    output logic                         busy,
    output logic                         done,
    output tpq_pkg::rsp_t                result,
    output tpq_pkg::mem_ctl_t            mem_ctl,
    output logic [IDX_W-1:0]             rd_addr,
    output logic [IDX_W-1:0]             tag_waddr,
    output logic [tpq_pkg::TAG_BITS-1:0] tag_wdata,
    output logic [IDX_W-1:0]             next_waddr,
    output logic [IDX_W-1:0]             next_wdata,
    input  logic [tpq_pkg::TAG_BITS-1:0] rd_tag,
    input  logic [IDX_W-1:0]             rd_next
);

    tpq_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg  [0:tpq_pkg::NUM_LEVELS-1];
    logic [IDX_W-1:0] head_next [0:tpq_pkg::NUM_LEVELS-1];
    logic [IDX_W-1:0] tail_reg  [0:tpq_pkg::NUM_LEVELS-1];
    logic [IDX_W-1:0] tail_next [0:tpq_pkg::NUM_LEVELS-1];
    logic [CNT_W-1:0] count_reg  [0:tpq_pkg::NUM_LEVELS-1];
    logic [CNT_W-1:0] count_next [0:tpq_pkg::NUM_LEVELS-1];

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic [CNT_W-1:0] total_reg, total_next;

    // Operation latched at the transfer, carried into the execute cycle.
    tpq_pkg::op_t                 op_reg, op_new;
    logic [1:0]                   lvl_reg, lvl_new;
    logic [IDX_W-1:0]             ent_reg, ent_new;
    logic [tpq_pkg::TAG_BITS-1:0] tag_reg;

    logic          done_reg, done_next;
    tpq_pkg::rsp_t res_reg, res_next;

    logic       accept;
    logic       any_queued;
    logic       fresh_left;
    logic [1:0] pick;
    logic [1:0] req_lvl;
    logic [1:0] cur_lvl;

    assign accept     = start && (state_reg == tpq_pkg::S_IDLE);
    assign fresh_left = (fresh_reg != CNT_W'(DEPTH));
    assign any_queued = (count_reg[tpq_pkg::LVL_HIGH] != '0) ||
                        (count_reg[tpq_pkg::LVL_NORMAL] != '0) ||
                        (count_reg[tpq_pkg::LVL_LOW] != '0);

    always_comb
    begin
        if (count_reg[tpq_pkg::LVL_HIGH] != '0)
        begin
            pick = tpq_pkg::LVL_HIGH;
        end
        else if (count_reg[tpq_pkg::LVL_NORMAL] != '0)
        begin
            pick = tpq_pkg::LVL_NORMAL;
        end
        else
        begin
            pick = tpq_pkg::LVL_LOW;
        end
    end

    // A put at the unused level is a no-op, so its index is parked at low.
    assign req_lvl = (request.priority_req > tpq_pkg::LVL_HIGH) ?
                     tpq_pkg::LVL_LOW : request.priority_req;
    assign lvl_new = (request.command == tpq_pkg::CMD_GET) ? pick : req_lvl;
    assign cur_lvl = (state_reg == tpq_pkg::S_EXEC) ? lvl_reg : lvl_new;

    // A get reads the head entry; a put reads the free-list head for its link.
    assign rd_addr = (request.command == tpq_pkg::CMD_GET) ?
                     head_reg[cur_lvl] : free_head_reg;
    assign ent_new = ((request.command == tpq_pkg::CMD_GET) || !fresh_left) ?
                     rd_addr : fresh_reg[IDX_W-1:0];

    always_comb
    begin
        case (request.command)
            tpq_pkg::CMD_PUT:
            begin
                if (request.priority_req > tpq_pkg::LVL_HIGH)
                begin
                    op_new = tpq_pkg::OP_NOP;
                end
                else if (total_reg == CNT_W'(DEPTH))
                begin
                    op_new = tpq_pkg::OP_FULL;
                end
                else
                begin
                    op_new = tpq_pkg::OP_PUT;
                end
            end
            tpq_pkg::CMD_GET:
            begin
                op_new = any_queued ? tpq_pkg::OP_GET : tpq_pkg::OP_EMPTY;
            end
            tpq_pkg::CMD_ACCEL:
            begin
                op_new = (count_reg[tpq_pkg::LVL_LOW] != '0) ?
                         tpq_pkg::OP_ACCEL : tpq_pkg::OP_NOP;
            end
            default:
            begin
                op_new = tpq_pkg::OP_NOP;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        case (state_reg)
            tpq_pkg::S_IDLE: state_next = start ? tpq_pkg::S_EXEC : tpq_pkg::S_IDLE;
            tpq_pkg::S_EXEC: state_next = tpq_pkg::S_IDLE;
            default:         state_next = tpq_pkg::S_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        case (state_reg)
            tpq_pkg::S_IDLE:
            begin
                busy      = 1'b0;
                done_next = 1'b0;
            end
            tpq_pkg::S_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy      = 1'b0;
                done_next = 1'b0;
            end
        endcase
    end

    // Execute cycle: the memory read data is valid, apply the list update.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        total_next     = total_reg;
        mem_ctl.rd_en   = accept;
        mem_ctl.tag_we  = 1'b0;
        mem_ctl.next_we = 1'b0;
        tag_waddr      = ent_reg;
        tag_wdata      = tag_reg;
        next_waddr     = tail_reg[lvl_reg];
        next_wdata     = ent_reg;
        res_next       = '0;

        if (state_reg == tpq_pkg::S_EXEC)
        begin
            case (op_reg)
                tpq_pkg::OP_PUT:
                begin
                    mem_ctl.tag_we = 1'b1;
                    if (count_reg[lvl_reg] != '0)
                    begin
                        mem_ctl.next_we = 1'b1;
                    end
                    else
                    begin
                        head_next[lvl_reg] = ent_reg;
                    end
                    tail_next[lvl_reg]  = ent_reg;
                    count_next[lvl_reg] = count_reg[lvl_reg] + CNT_W'(1);
                    total_next          = total_reg + CNT_W'(1);
                    if (fresh_left)
                    begin
                        fresh_next = fresh_reg + CNT_W'(1);
                    end
                    else
                    begin
                        free_head_next = rd_next;
                    end
                end
                tpq_pkg::OP_FULL:
                begin
                    res_next.status = tpq_pkg::STATUS_FULL;
                end
                tpq_pkg::OP_GET:
                begin
                    head_next[lvl_reg]  = rd_next;
                    count_next[lvl_reg] = count_reg[lvl_reg] - CNT_W'(1);
                    if (count_reg[lvl_reg] == CNT_W'(1))
                    begin
                        head_next[lvl_reg] = '0;
                        tail_next[lvl_reg] = '0;
                    end
                    total_next         = total_reg - CNT_W'(1);
                    // Released entry goes on top of the free list.
                    mem_ctl.next_we    = 1'b1;
                    next_waddr         = ent_reg;
                    next_wdata         = free_head_reg;
                    free_head_next     = ent_reg;
                    res_next.out_tag   = rd_tag;
                    res_next.out_level = lvl_reg;
                end
                tpq_pkg::OP_EMPTY:
                begin
                    res_next.status = tpq_pkg::STATUS_EMPTY;
                end
                tpq_pkg::OP_ACCEL:
                begin
                    if (count_reg[tpq_pkg::LVL_HIGH] == '0)
                    begin
                        head_next[tpq_pkg::LVL_HIGH] = head_reg[tpq_pkg::LVL_LOW];
                    end
                    else
                    begin
                        mem_ctl.next_we = 1'b1;
                        next_waddr      = tail_reg[tpq_pkg::LVL_HIGH];
                        next_wdata      = head_reg[tpq_pkg::LVL_LOW];
                    end
                    tail_next[tpq_pkg::LVL_HIGH]  = tail_reg[tpq_pkg::LVL_LOW];
                    count_next[tpq_pkg::LVL_HIGH] = count_reg[tpq_pkg::LVL_HIGH] +
                                                    count_reg[tpq_pkg::LVL_LOW];
                    count_next[tpq_pkg::LVL_LOW]  = '0;
                    head_next[tpq_pkg::LVL_LOW]   = '0;
                    tail_next[tpq_pkg::LVL_LOW]   = '0;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpq_pkg::S_IDLE;
            done_reg      <= 1'b0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            total_reg     <= '0;
            for (int i = 0; i < tpq_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            total_reg     <= total_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_new;
            lvl_reg <= lvl_new;
            ent_reg <= ent_new;
            tag_reg <= request.tag;
        end
        if (state_reg == tpq_pkg::S_EXEC)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/three_level_priority_queue_unit.sv -----
// Channel   Direction  Handshake                   Payload
// request   in         start high, busy low        tpq_pkg::req_t (command, level, tag)
// result    out        done high for one cycle     tpq_pkg::rsp_t (status, tag, level)
//
// The transfer cycle of a command issues one read of the entry store, the
// following cycle writes back the list update, and the result is shown with
// done in the cycle after that. Since the entry store read is registered, the
// update is applied in the execute cycle, and no command is taken while busy.
// Reset clears all list pointers and counts; the entry store needs no clearing.
// The result receiver cannot stall: done is a single-cycle strobe.
module three_level_priority_queue_unit #(
    parameter int unsigned POOL_DEPTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tpq_pkg::req_t request,
    output logic          busy,
    output logic          done,
    output tpq_pkg::rsp_t result
);

    // Entry index width and a count width that can hold the pool depth itself.
    localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);

    tpq_pkg::mem_ctl_t            mem_ctl;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             tag_waddr;
    logic [tpq_pkg::TAG_BITS-1:0] tag_wdata;
    logic [IDX_W-1:0]             next_waddr;
    logic [IDX_W-1:0]             next_wdata;
    logic [tpq_pkg::TAG_BITS-1:0] rd_tag;
    logic [IDX_W-1:0]             rd_next;

    // The controller holds the head, tail and count of each level plus the
    // free-list head and the fresh-entry counter. Each level is a singly linked
    // list threaded through the link memory of the shared entry store.
    // Because a command is taken only after the previous write-back has landed,
    // a read never overlaps a pending write to the same entry.
    tpq_ctrl #(
        .DEPTH (POOL_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .mem_ctl    (mem_ctl),
        .rd_addr    (rd_addr),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .rd_tag     (rd_tag),
        .rd_next    (rd_next)
    );

    // Tag and link memories of the shared pool.
    tpq_store #(
        .DEPTH (POOL_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk        (clk),
        .ctl        (mem_ctl),
        .rd_addr    (rd_addr),
        .tag_waddr  (tag_waddr),
        .tag_wdata  (tag_wdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .rd_tag     (rd_tag),
        .rd_next    (rd_next)
    );

    // The execute state always returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n) busy |=> !busy)
        else $error("busy held for more than one cycle");

    // Every transfer gives its result: it passes the execute state, then the done register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after a transfer");

    // A result only follows an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result without a preceding execute cycle");

    // A failed command carries neither tag nor level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != tpq_pkg::STATUS_OK) |->
        (result.out_tag == '0 && result.out_level == '0))
        else $error("failed command returned a tag or level");

endmodule
